FILE: hw/rtl/global_alignment_last_row_top_macros.svh
// Assertion helpers used by the checker file.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef GLOBAL_ALIGNMENT_LAST_ROW_TOP_MACROS_SVH
`define GLOBAL_ALIGNMENT_LAST_ROW_TOP_MACROS_SVH

// Same-cycle implication.
`define GAL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/gal_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gal_pkg
// Shared widths, command codes and the cell control bundle.
// ---------------------------------------------------------------------------
package gal_pkg;

  localparam int SYM_W   = 8;
  localparam int COL_W   = 6;
  localparam int SCORE_W = 10;

  localparam logic CMD_REF  = 1'b0;
  localparam logic CMD_WORD = 1'b1;

  typedef struct packed {
    logic             row_init;
    logic             shift;
    logic             ref_load;
    logic [COL_W-1:0] ref_idx;
    logic [SYM_W-1:0] ref_sym;
    logic [COL_W-1:0] ref_len;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/gal_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gal_in_if
// Input channel: reference or word symbol beats.
// ---------------------------------------------------------------------------
interface gal_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [gal_pkg::SYM_W-1:0] symbol;
  logic                      is_last;

  modport source (output valid, output command, output symbol, output is_last,
                  input ready);
  modport sink   (input valid, input command, input symbol, input is_last,
                  output ready);
endinterface

FILE: hw/rtl/gal_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gal_out_if
// Result channel: one score beat per reference prefix length.
// ---------------------------------------------------------------------------
interface gal_out_if;
  logic                               valid;
  logic                               ready;
  logic        [gal_pkg::COL_W-1:0]   column;
  logic signed [gal_pkg::SCORE_W-1:0] score;
  logic                               truncated;
  logic                               end_of_row;

  modport source (output valid, output column, output score, output truncated,
                  output end_of_row, input ready);
  modport sink   (input valid, input column, input score, input truncated,
                  input end_of_row, output ready);
endinterface

FILE: hw/rtl/gal_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gal_cell
// One reference column: holds its symbol and score, updates on a passing
// word token and hands the token on to the next column.
// ---------------------------------------------------------------------------
module gal_cell #(
  parameter int IDX = 1,
  parameter int SW  = 10,
  parameter int SB  = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gal_pkg::cell_ctrl_t        ctrl,
  input  logic                       in_vld,
  input  logic        [SB-1:0]       in_sym,
  input  logic signed [SW-1:0]       in_left,
  input  logic signed [SW-1:0]       in_diag,
  input  logic signed [SW-1:0]       shift_in,
  output logic                       out_vld,
  output logic        [SB-1:0]       out_sym,
  output logic signed [SW-1:0]       out_left,
  output logic signed [SW-1:0]       out_diag,
  output logic signed [SW-1:0]       score
);

  localparam logic        [gal_pkg::COL_W-1:0] MY_COL     = gal_pkg::COL_W'(IDX);
  localparam logic        [gal_pkg::COL_W-1:0] PREV_COL   = gal_pkg::COL_W'(IDX - 1);
  localparam logic signed [SW-1:0]             INIT_SCORE = SW'(-IDX);

  logic        [SB-1:0] ref_r;
  logic signed [SW-1:0] score_r;
  logic                 vld_r;
  logic        [SB-1:0] sym_r;
  logic signed [SW-1:0] left_r;
  logic signed [SW-1:0] diag_r;

  logic                 active;
  logic signed [SW-1:0] cand_diag;
  logic signed [SW-1:0] cand_up;
  logic signed [SW-1:0] cand_left;
  logic signed [SW-1:0] best_du;
  logic signed [SW-1:0] score_nxt;

  assign active    = (MY_COL <= ctrl.ref_len);
  assign cand_diag = (ref_r == in_sym) ? in_diag + SW'(1) : in_diag - SW'(1);
  assign cand_up   = score_r - SW'(1);
  assign cand_left = in_left - SW'(1);

  always_comb begin
    best_du   = (cand_diag > cand_up) ? cand_diag : cand_up;
    score_nxt = (best_du > cand_left) ? best_du : cand_left;
  end

  always_ff @(posedge clk) begin
    if (ctrl.ref_load && (ctrl.ref_idx == PREV_COL)) begin
      ref_r <= ctrl.ref_sym[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.row_init) begin
      score_r <= INIT_SCORE;
    end else if (ctrl.shift) begin
      score_r <= shift_in;
    end else if (in_vld && active) begin
      score_r <= score_nxt;
    end
  end

  // Token stage toward the next column.
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.row_init) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    sym_r  <= in_sym;
    left_r <= score_nxt;
    diag_r <= score_r;
  end

  assign out_vld  = vld_r;
  assign out_sym  = sym_r;
  assign out_left = left_r;
  assign out_diag = diag_r;
  assign score    = score_r;

endmodule

FILE: hw/rtl/global_alignment_last_row_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// global_alignment_last_row_top
// Needleman-Wunsch last-row scorer over a systolic row of column cells.
// ---------------------------------------------------------------------------
// Reference symbols load one per cycle while input is open, each into its
// column cell. Word symbols are also taken one per cycle while input is
// open: each enters a skewed wavefront that moves through the row of
// MAX_REF cells one column per cycle. After the beat marked is_last the
// input holds off while the wavefront clears the chain, then the row of
// m + 1 scores shifts out of the chain one beat per cycle while the result
// side keeps up; after the last beat input opens again at once. Reference
// beats emit nothing. No clearing pass follows reset.
module global_alignment_last_row_top #(
  parameter int MAX_REF     = 63,
  parameter int MAX_WORD    = 255,
  parameter int SYMBOL_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  gal_in_if.sink    in_bus,
  gal_out_if.source out_bus
);

  localparam int RW     = $clog2(MAX_WORD + 1);
  localparam int SW_RAW = $clog2(MAX_WORD + MAX_REF + 1) + 1;
  localparam int SW     = (SW_RAW > gal_pkg::SCORE_W) ? SW_RAW : gal_pkg::SCORE_W;
  localparam int SB     = SYMBOL_BITS;

  localparam logic [gal_pkg::COL_W-1:0] MAX_REF_C  = gal_pkg::COL_W'(MAX_REF);
  localparam logic [RW-1:0]             MAX_WORD_C = RW'(MAX_WORD);
  localparam logic signed [SW-1:0]      SAT_HI     = SW'(511);
  localparam logic signed [SW-1:0]      SAT_LO     = -SW'(512);

  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_DRAIN = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t                      state_r, state_nxt;
  logic                        open_r;
  logic [gal_pkg::COL_W-1:0]   len_r;
  logic                        ref_ovf_r;
  logic                        word_ovf_r;
  logic [RW-1:0]               rows_done_r;
  logic [gal_pkg::COL_W-1:0]   col_r;

  logic                        tok_vld_r;
  logic        [SB-1:0]        tok_sym_r;
  logic signed [SW-1:0]        tok_left_r;
  logic signed [SW-1:0]        tok_diag_r;

  logic                        out_valid_r;
  logic [gal_pkg::COL_W-1:0]   out_column_r;
  logic signed [gal_pkg::SCORE_W-1:0] out_score_r;
  logic                        out_trunc_r;
  logic                        out_eor_r;

  logic                        in_acc;
  logic                        is_ref;
  logic                        is_word;
  logic                        start_ref;
  logic [gal_pkg::COL_W-1:0]   eff_len;
  logic                        can_append;
  logic                        advance;
  logic                        emit_load;
  logic                        emit_done;
  logic signed [SW-1:0]        rd_s;
  logic signed [SW-1:0]        emit_sel;
  logic signed [gal_pkg::SCORE_W-1:0] emit_sat;
  gal_pkg::cell_ctrl_t         ctrl;

  logic        [MAX_REF:0]     tv;
  logic        [SB-1:0]        ts [0:MAX_REF];
  logic signed [SW-1:0]        tl [0:MAX_REF];
  logic signed [SW-1:0]        td [0:MAX_REF];
  logic signed [SW-1:0]        sc [1:MAX_REF+1];

  assign in_bus.ready = (state_r == ST_RUN);
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign is_ref       = in_acc && (in_bus.command == gal_pkg::CMD_REF);
  assign is_word      = in_acc && (in_bus.command == gal_pkg::CMD_WORD);
  assign start_ref    = is_ref && !open_r;
  assign eff_len      = open_r ? len_r : '0;
  assign can_append   = (eff_len < MAX_REF_C);
  assign advance      = is_word && (rows_done_r < MAX_WORD_C);

  assign emit_load = (state_r == ST_EMIT) && (!out_valid_r || out_bus.ready);
  assign emit_done = emit_load && (col_r == len_r);

  always_comb begin
    ctrl.row_init = start_ref || emit_done;
    ctrl.shift    = emit_load && (col_r != '0);
    ctrl.ref_load = is_ref && can_append;
    ctrl.ref_idx  = eff_len;
    ctrl.ref_sym  = in_bus.symbol;
    ctrl.ref_len  = len_r;
  end

  // Column zero holds -rows; ~x gives -(x+1) for the next row.
  assign rd_s = SW'(rows_done_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN: begin
        if (is_word && in_bus.is_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (tv == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_done) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r    <= 1'b0;
      len_r     <= '0;
      ref_ovf_r <= 1'b0;
    end else if (is_ref) begin
      open_r    <= !in_bus.is_last;
      len_r     <= can_append ? eff_len + gal_pkg::COL_W'(1) : eff_len;
      ref_ovf_r <= (open_r && ref_ovf_r) || !can_append;
    end else if (is_word) begin
      open_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.row_init) begin
      rows_done_r <= '0;
      word_ovf_r  <= 1'b0;
    end else if (advance) begin
      rows_done_r <= rows_done_r + RW'(1);
    end else if (is_word) begin
      word_ovf_r <= 1'b1;
    end
  end

  // Wavefront entry stage feeding column one.
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.row_init) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= advance;
    end
  end

  always_ff @(posedge clk) begin
    tok_sym_r  <= in_bus.symbol[SB-1:0];
    tok_left_r <= ~rd_s;
    tok_diag_r <= -rd_s;
  end

  assign tv[0] = tok_vld_r;
  assign ts[0] = tok_sym_r;
  assign tl[0] = tok_left_r;
  assign td[0] = tok_diag_r;
  assign sc[MAX_REF+1] = '0;

  for (genvar k = 1; k <= MAX_REF; k++) begin : g_cell
    gal_cell #(
      .IDX(k),
      .SW (SW),
      .SB (SB)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .in_vld  (tv[k-1]),
      .in_sym  (ts[k-1]),
      .in_left (tl[k-1]),
      .in_diag (td[k-1]),
      .shift_in(sc[k+1]),
      .out_vld (tv[k]),
      .out_sym (ts[k]),
      .out_left(tl[k]),
      .out_diag(td[k]),
      .score   (sc[k])
    );
  end

  // Column zero comes from the row counter, the rest shift out of cell one.
  assign emit_sel = (col_r == '0) ? -rd_s : sc[1];

  always_comb begin
    if (emit_sel > SAT_HI) begin
      emit_sat = gal_pkg::SCORE_W'(511);
    end else if (emit_sel < SAT_LO) begin
      emit_sat = -gal_pkg::SCORE_W'(512);
    end else begin
      emit_sat = emit_sel[gal_pkg::SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (emit_done) begin
      col_r <= '0;
    end else if (emit_load) begin
      col_r <= col_r + gal_pkg::COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_column_r <= col_r;
      out_score_r  <= emit_sat;
      out_trunc_r  <= word_ovf_r || ref_ovf_r;
      out_eor_r    <= (col_r == len_r);
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.column     = out_column_r;
  assign out_bus.score      = out_score_r;
  assign out_bus.truncated  = out_trunc_r;
  assign out_bus.end_of_row = out_eor_r;

endmodule

FILE: hw/rtl/gal_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gal_checker
// Port-level checks on the scorer: stalled-beat hold, row emission order, column zero sign and input hold-off.
// ---------------------------------------------------------------------------
`include "global_alignment_last_row_top_macros.svh"

module gal_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic        [gal_pkg::COL_W-1:0]   out_column,
  input logic signed [gal_pkg::SCORE_W-1:0] out_score,
  input logic                               out_end_of_row
);

  // A stalled beat holds.
  `GAL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_column) && $stable(out_score) && $stable(out_end_of_row), "stalled result beat changed")

  // Inside a row the next column follows right away.
  `GAL_ASSERT_NEXT(a_col_step, out_valid && out_ready && !out_end_of_row, out_valid && (out_column == $past(out_column) + gal_pkg::COL_W'(1)), "row columns not consecutive")

  // Empty reference prefix scores minus the word length.
  `GAL_ASSERT_SAME(a_col0_neg, out_valid && (out_column == '0), out_score[gal_pkg::SCORE_W-1] || (out_score == '0), "column zero score positive")

  // Input stays closed while a row is being emitted.
  `GAL_ASSERT_SAME(a_in_hold, out_valid && !out_end_of_row, !in_ready, "input open during row emission")

endmodule

bind global_alignment_last_row_top gal_checker u_gal_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_bus.ready),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .out_column    (out_bus.column),
  .out_score     (out_bus.score),
  .out_end_of_row(out_bus.end_of_row)
);
